// ===== hdl/concat_volume_block_mapper_core_defines.svh =====
// Assertion macros for the concatenated-volume block mapper.
// Used by the top level only; expects signals clk and rst in scope.
`ifndef CONCAT_VOLUME_BLOCK_MAPPER_CORE_DEFINES_SVH
`define CONCAT_VOLUME_BLOCK_MAPPER_CORE_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define CVBM_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// An implication checked in the same cycle.
`define CVBM_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// An implication whose consequent is checked in the cycle after the antecedent.
`define CVBM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/cvbm_pkg.sv =====
// Shared types and constants of the concatenated-volume block mapper.
// No dependencies; every other file of the block but the defines header uses it.
package cvbm_pkg;

  localparam int NMEM     = 4;
  localparam int ADDR_W   = 48;
  localparam int POS_W    = ADDR_W + 1;
  localparam int CNT_W    = 32;
  localparam int KIND_W   = 2;
  localparam int IDX_W    = 2;
  localparam int SHIFT_W  = 5;
  localparam int MC_W     = 3;
  localparam int DATA_W   = 64;
  localparam int PADDR_W  = 6;
  localparam int REG_W    = 3;

  // Cycles for the member start chain and the volume size to settle after a write.
  localparam int SETTLE_CYCLES = NMEM + 2;
  localparam int SETTLE_W      = $clog2(SETTLE_CYCLES + 1);

  localparam logic [ADDR_W-1:0] ADDR_MAX = {ADDR_W{1'b1}};

  localparam logic [KIND_W-1:0] OP_READ  = 2'd0;
  localparam logic [KIND_W-1:0] OP_WRITE = 2'd1;
  localparam logic [KIND_W-1:0] OP_UNMAP = 2'd2;
  localparam logic [KIND_W-1:0] OP_FLUSH = 2'd3;

  localparam logic [REG_W-1:0] REG_STRIP_SHIFT  = 3'd0;
  localparam logic [REG_W-1:0] REG_MEMBER_COUNT = 3'd1;
  localparam logic [REG_W-1:0] REG_RAW0         = 3'd2;
  localparam logic [REG_W-1:0] REG_RAW1         = 3'd3;
  localparam logic [REG_W-1:0] REG_RAW2         = 3'd4;
  localparam logic [REG_W-1:0] REG_RAW3         = 3'd5;

  typedef struct packed {
    logic [KIND_W-1:0] opcode;
    logic [ADDR_W-1:0] volume_offset;
    logic [CNT_W-1:0]  block_count;
  } req_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  member_index;
    logic [ADDR_W-1:0] member_lba;
    logic [CNT_W-1:0]  piece_blocks;
    logic              range_error;
    logic              last_piece;
  } rsp_t;

  typedef struct packed {
    logic [SHIFT_W-1:0]           strip_shift;
    logic [MC_W-1:0]              n;
    logic [NMEM-1:0][ADDR_W-1:0] raw;
    logic                         written;
  } cfg_t;

  // Request as it walks down the row of member cells.
  typedef struct packed {
    logic              valid;
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] off;
    logic [POS_W-1:0]  pos;
    logic [CNT_W-1:0]  rem;
    logic              err;
    logic              done;
    logic [IDX_W-1:0]  idx;
    logic [ADDR_W-1:0] lba;
  } tok_t;

  typedef struct packed {
    logic valid;
    rsp_t data;
  } piece_t;

  typedef struct packed {
    logic adv;
    logic fin_valid;
    logic fin_done;
  } col_status_t;

endpackage

// ===== hdl/cvbm_regs.sv =====
// APB register file: strip shift, member count and raw member sizes.
// Depends on cvbm_pkg.
module cvbm_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cvbm_pkg::PADDR_W-1:0]  paddr,
  input  logic [cvbm_pkg::DATA_W-1:0]   pwdata,
  output logic [cvbm_pkg::DATA_W-1:0]   prdata,
  output cvbm_pkg::cfg_t                cfg
);

  logic [cvbm_pkg::SHIFT_W-1:0]                   strip_shift;
  logic [cvbm_pkg::MC_W-1:0]                      member_count;
  logic [cvbm_pkg::NMEM-1:0][cvbm_pkg::ADDR_W-1:0] raw;
  logic [cvbm_pkg::REG_W-1:0]                     idx;
  logic                                           wr;

  assign idx = paddr[cvbm_pkg::PADDR_W-1:3];
  assign wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      strip_shift  <= '0;
      member_count <= cvbm_pkg::MC_W'(1);
      raw          <= '0;
    end else if (wr) begin
      unique case (idx)
        cvbm_pkg::REG_STRIP_SHIFT:  strip_shift  <= pwdata[cvbm_pkg::SHIFT_W-1:0];
        cvbm_pkg::REG_MEMBER_COUNT: member_count <= pwdata[cvbm_pkg::MC_W-1:0];
        cvbm_pkg::REG_RAW0:         raw[0] <= pwdata[cvbm_pkg::ADDR_W-1:0];
        cvbm_pkg::REG_RAW1:         raw[1] <= pwdata[cvbm_pkg::ADDR_W-1:0];
        cvbm_pkg::REG_RAW2:         raw[2] <= pwdata[cvbm_pkg::ADDR_W-1:0];
        cvbm_pkg::REG_RAW3:         raw[3] <= pwdata[cvbm_pkg::ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      cvbm_pkg::REG_STRIP_SHIFT:  prdata = cvbm_pkg::DATA_W'(strip_shift);
      cvbm_pkg::REG_MEMBER_COUNT: prdata = cvbm_pkg::DATA_W'(member_count);
      cvbm_pkg::REG_RAW0:         prdata = cvbm_pkg::DATA_W'(raw[0]);
      cvbm_pkg::REG_RAW1:         prdata = cvbm_pkg::DATA_W'(raw[1]);
      cvbm_pkg::REG_RAW2:         prdata = cvbm_pkg::DATA_W'(raw[2]);
      cvbm_pkg::REG_RAW3:         prdata = cvbm_pkg::DATA_W'(raw[3]);
      default:                    prdata = '0;
    endcase
  end

  // A member count of zero acts as one; larger values clamp to the member slots.
  always_comb begin
    cfg.strip_shift = strip_shift;
    cfg.raw         = raw;
    cfg.written     = wr;
    if (member_count == '0) begin
      cfg.n = cvbm_pkg::MC_W'(1);
    end else if (member_count > cvbm_pkg::MC_W'(cvbm_pkg::NMEM)) begin
      cfg.n = cvbm_pkg::MC_W'(cvbm_pkg::NMEM);
    end else begin
      cfg.n = member_count;
    end
  end

endmodule

// ===== hdl/cvbm_cell.sv =====
// One member cell: holds the member's rounded length and start, forwards the
// running start to its neighbor, and maps the request token passing through.
// Depends on cvbm_pkg.
module cvbm_cell (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           active,
  input  logic [cvbm_pkg::IDX_W-1:0]     cell_idx,
  input  logic [cvbm_pkg::ADDR_W-1:0]    raw,
  input  logic [cvbm_pkg::SHIFT_W-1:0]   strip_shift,
  input  logic [cvbm_pkg::ADDR_W-1:0]    start_in,
  output logic [cvbm_pkg::ADDR_W-1:0]    start_out,
  input  cvbm_pkg::tok_t                 tok_in,
  output cvbm_pkg::tok_t                 tok_out,
  output cvbm_pkg::piece_t               piece
);

  logic [cvbm_pkg::ADDR_W-1:0] len_r;
  logic [cvbm_pkg::ADDR_W-1:0] start_r;
  cvbm_pkg::tok_t              tok;
  logic [cvbm_pkg::POS_W-1:0]  mend;
  logic [cvbm_pkg::POS_W-1:0]  pb_full;
  logic [cvbm_pkg::POS_W-1:0]  lba_w;
  logic [cvbm_pkg::POS_W-1:0]  rem_w;
  logic [cvbm_pkg::CNT_W-1:0]  pb;

  // Length and start are refreshed every cycle, so the start chain settles after
  // any register write once the change has passed through each start register.
  always_ff @(posedge clk) begin
    len_r   <= active ? ((raw >> strip_shift) << strip_shift) : '0;
    start_r <= start_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok.valid <= 1'b0;
    end else if (en) begin
      tok <= tok_in;
    end
  end

  assign mend      = {1'b0, start_r} + {1'b0, len_r};
  assign start_out = mend[cvbm_pkg::ADDR_W] ? cvbm_pkg::ADDR_MAX : mend[cvbm_pkg::ADDR_W-1:0];
  assign pb_full   = mend - tok.pos;
  assign lba_w     = tok.pos - {1'b0, start_r};
  assign rem_w     = cvbm_pkg::POS_W'(tok.rem);

  always_comb begin
    tok_out = tok;
    piece   = '0;
    pb      = '0;
    if (tok.valid && active) begin
      if (tok.kind == cvbm_pkg::OP_READ || tok.kind == cvbm_pkg::OP_WRITE) begin
        // Starts never decrease, so the last cell that matches wins.
        if (start_r <= tok.off) begin
          tok_out.idx = cell_idx;
          tok_out.lba = tok.off - start_r;
        end
      end else if (!tok.done && tok.pos < mend) begin
        if (rem_w <= pb_full) begin
          pb           = tok.rem;
          tok_out.done = 1'b1;
        end else begin
          pb = pb_full[cvbm_pkg::CNT_W-1:0];
        end
        tok_out.pos               = mend;
        tok_out.rem               = tok.rem - pb;
        piece.valid               = 1'b1;
        piece.data.kind           = tok.kind;
        piece.data.member_index   = cell_idx;
        piece.data.member_lba     = lba_w[cvbm_pkg::ADDR_W-1:0];
        piece.data.piece_blocks   = pb;
        piece.data.range_error    = tok.err;
        piece.data.last_piece     = 1'b0;
      end
    end
  end

endmodule

// ===== hdl/cvbm_collect.sv =====
// Piece collector: holds one piece back until the next one or the end of the
// request shows whether it is the last, and drives the result register.
// Depends on cvbm_pkg.
module cvbm_collect (
  input  logic                  clk,
  input  logic                  rst,
  input  cvbm_pkg::piece_t      piece_in,
  input  cvbm_pkg::tok_t        tok_in,
  input  logic                  rsp_ready,
  output logic                  rsp_valid,
  output cvbm_pkg::rsp_t        rsp,
  output cvbm_pkg::col_status_t status
);

  cvbm_pkg::tok_t fin;
  cvbm_pkg::rsp_t pend;
  logic           pend_v;
  logic           adv;
  logic           push_v;
  cvbm_pkg::rsp_t push_d;

  assign adv = !rsp_valid || rsp_ready;

  always_comb begin
    push_v = 1'b0;
    push_d = pend;
    if (fin.valid) begin
      push_v = 1'b1;
      if (fin.kind == cvbm_pkg::OP_READ || fin.kind == cvbm_pkg::OP_WRITE) begin
        push_d.kind         = fin.kind;
        push_d.member_index = fin.idx;
        push_d.member_lba   = fin.lba;
        push_d.piece_blocks = fin.rem;
        push_d.range_error  = fin.err;
        push_d.last_piece   = 1'b1;
      end else if (pend_v) begin
        push_d.last_piece = 1'b1;
      end else begin
        // The request starts at or past the volume end.
        push_d.kind         = fin.kind;
        push_d.member_index = '0;
        push_d.member_lba   = '0;
        push_d.piece_blocks = '0;
        push_d.range_error  = 1'b1;
        push_d.last_piece   = 1'b1;
      end
    end else if (piece_in.valid && pend_v) begin
      push_v = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin.valid <= 1'b0;
      pend_v    <= 1'b0;
      rsp_valid <= 1'b0;
    end else if (adv) begin
      fin       <= tok_in;
      rsp_valid <= push_v;
      if (push_v) begin
        rsp <= push_d;
      end
      if (piece_in.valid) begin
        pend   <= piece_in.data;
        pend_v <= 1'b1;
      end else if (fin.valid) begin
        pend_v <= 1'b0;
      end
    end
  end

  assign status.adv       = adv;
  assign status.fin_valid = fin.valid;
  assign status.fin_done  = adv && fin.valid;

endmodule

// ===== hdl/concat_volume_block_mapper_core.sv =====
// Top level of the concatenated-volume block mapper: register file, row of
// member cells and piece collector. Depends on cvbm_pkg and the defines header.
//
//   port group        | handshake              | carries
//   ------------------+------------------------+---------------------------
//   req               | req_valid / req_ready  | opcode, offset, block count
//   rsp               | rsp_valid / rsp_ready  | one mapped piece
//   apb               | psel, penable, pready  | register writes and reads
//
// A request walks the row of four member cells, one cell per cycle while the
// result side does not stall, then passes into the collector's final register.
// Its last piece enters the result register from there, and the next request
// is taken only after that, so one request at a time is in the row.
// After reset and after each register write, req_ready stays low while the
// settle counter runs down and the member starts and the volume size settle.
// A stalled result register holds the whole row in place.
`include "concat_volume_block_mapper_core_defines.svh"

module concat_volume_block_mapper_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  cvbm_pkg::req_t                req,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output cvbm_pkg::rsp_t                rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cvbm_pkg::PADDR_W-1:0]  paddr,
  input  logic [cvbm_pkg::DATA_W-1:0]   pwdata,
  output logic [cvbm_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  cvbm_pkg::cfg_t                                   cfg;
  cvbm_pkg::col_status_t                            st;
  cvbm_pkg::tok_t [cvbm_pkg::NMEM:0]                tok_chain;
  logic [cvbm_pkg::NMEM:0][cvbm_pkg::ADDR_W-1:0]    start_chain;
  cvbm_pkg::piece_t [cvbm_pkg::NMEM-1:0]            pieces;
  cvbm_pkg::piece_t                                 piece_sel;
  logic [cvbm_pkg::NMEM-1:0]                        tok_v;
  logic [cvbm_pkg::ADDR_W-1:0]                      total;
  logic [cvbm_pkg::SETTLE_W-1:0]                    settle;
  logic                                             busy;
  logic                                             req_fire;
  logic [cvbm_pkg::POS_W-1:0]                       req_end;
  cvbm_pkg::tok_t                                   new_tok;
  logic                                             rsp_rw;

  assign pready   = 1'b1;
  assign req_ready = !busy && (settle == '0);
  assign req_fire  = req_valid && req_ready;

  cvbm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  always_ff @(posedge clk) begin
    if (rst || cfg.written) begin
      settle <= cvbm_pkg::SETTLE_W'(cvbm_pkg::SETTLE_CYCLES);
    end else if (settle != '0) begin
      settle <= settle - cvbm_pkg::SETTLE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (req_fire) begin
      busy <= 1'b1;
    end else if (st.fin_done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    total <= start_chain[cvbm_pkg::NMEM];
  end

  assign req_end = cvbm_pkg::POS_W'(req.volume_offset) + cvbm_pkg::POS_W'(req.block_count);

  always_comb begin
    new_tok       = '0;
    new_tok.valid = req_fire;
    new_tok.kind  = req.opcode;
    new_tok.off   = req.volume_offset;
    new_tok.pos   = cvbm_pkg::POS_W'(req.volume_offset);
    new_tok.rem   = req.block_count;
    new_tok.err   = req_end > cvbm_pkg::POS_W'(total);
    new_tok.lba   = req.volume_offset;
  end

  assign tok_chain[0]   = new_tok;
  assign start_chain[0] = '0;

  for (genvar g = 0; g < cvbm_pkg::NMEM; g++) begin : g_cell
    cvbm_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .en          ((g == 0) ? (st.adv || req_fire) : st.adv),
      .active      (cfg.n > cvbm_pkg::MC_W'(g)),
      .cell_idx    (cvbm_pkg::IDX_W'(g)),
      .raw         (cfg.raw[g]),
      .strip_shift (cfg.strip_shift),
      .start_in    (start_chain[g]),
      .start_out   (start_chain[g+1]),
      .tok_in      (tok_chain[g]),
      .tok_out     (tok_chain[g+1]),
      .piece       (pieces[g])
    );
    assign tok_v[g] = tok_chain[g+1].valid;
  end

  // Only one request is in the row, so at most one cell offers a piece.
  always_comb begin
    piece_sel = '0;
    for (int i = 0; i < cvbm_pkg::NMEM; i++) begin
      if (pieces[i].valid) begin
        piece_sel = pieces[i];
      end
    end
  end

  cvbm_collect u_collect (
    .clk       (clk),
    .rst       (rst),
    .piece_in  (piece_sel),
    .tok_in    (tok_chain[cvbm_pkg::NMEM]),
    .rsp_ready (rsp_ready),
    .rsp_valid (rsp_valid),
    .rsp       (rsp),
    .status    (st)
  );

  assign rsp_rw = (rsp.kind == cvbm_pkg::OP_READ) || (rsp.kind == cvbm_pkg::OP_WRITE);

  `CVBM_ASSERT(a_single_request, $countones({tok_v, st.fin_valid}) <= 1, "two requests in the row")
  `CVBM_ASSERT_NEXT(a_request_enters_row, req_fire, tok_v[0], "request missed the first cell")
  `CVBM_ASSERT_IMPL(a_rw_single_piece, rsp_valid && rsp_rw, rsp.last_piece, "rw piece not last")
  `CVBM_ASSERT_IMPL(a_idle_when_ready, req_ready, tok_v == '0 && !st.fin_valid, "row not empty")

endmodule
